// ===== rtl/ptok_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptok_pkg
// Shared constants, result codes and byte classes for the command tokenizer.
// ----------------------------------------------------------------------------
package ptok_pkg;

   // default sizes, handed to the top level parameters
   localparam int MAX_COMMANDS_DEF = 8;
   localparam int MAX_ARGS_DEF     = 8;
   localparam int HOLD_DEPTH_DEF   = 56;

   // payload widths
   localparam int CHAR_W   = 8;
   localparam int KIND_W   = 2;
   localparam int NUM_W    = 3;
   localparam int STATUS_W = 2;
   localparam int CMD_CNT_W = 4;

   localparam logic [CMD_CNT_W-1:0] CMD_COUNT_MAX = 4'hF;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_ARG_BYTE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ARG_END  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CMD_END  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_STATUS   = 2'd3;

   // line status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_CMDS  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TOO_MANY = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd3;

   // latched line errors
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_WS_SEG   = 2'd1;
   localparam logic [1:0] ERR_OVERFLOW = 2'd3;

   // special bytes
   localparam logic [CHAR_W-1:0] PIPE_BYTE = 8'h7C;
   localparam logic [CHAR_W-1:0] DQUOTE    = 8'h22;
   localparam logic [CHAR_W-1:0] SQUOTE    = 8'h27;

   // space, tab, LF, VT, FF, CR
   function automatic logic is_ws(input logic [CHAR_W-1:0] c);
      return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
   endfunction

endpackage

// ===== rtl/ptok_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptok_if
// Valid/ready channels for input bytes and tokenizer results.
// ----------------------------------------------------------------------------
interface ptok_req_if import ptok_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_value;
   logic              end_of_line;

   modport source (output valid, char_value, end_of_line, input ready);
   modport sink   (input valid, char_value, end_of_line, output ready);
endinterface

interface ptok_rsp_if import ptok_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [CHAR_W-1:0]   arg_byte;
   logic [NUM_W-1:0]    command_number;
   logic [NUM_W-1:0]    argument_number;
   logic [STATUS_W-1:0] line_status;
   logic                last_of_run;

   modport source (output valid, kind, arg_byte, command_number, argument_number,
                   line_status, last_of_run, input ready);
   modport sink   (input valid, kind, arg_byte, command_number, argument_number,
                   line_status, last_of_run, output ready);
endinterface

// ===== rtl/ptok_hold_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptok_hold_mem
// Buffer for whitespace held inside an open quote; one write port and one
// read port with registered read data.
// ----------------------------------------------------------------------------
module ptok_hold_mem import ptok_pkg::*; #(
   parameter int DEPTH = HOLD_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [CHAR_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [CHAR_W-1:0]        rd_data
);

   logic [CHAR_W-1:0] mem [0:DEPTH-1];
   logic [CHAR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pipe_and_quote_command_tokenizer_core.sv =====
`timescale 1ns / 1ps
// A byte's results are issued from the emit state through the output register;
//   no new byte is taken until the last result of the current byte has been loaded.
//   The output sequencer issues one result per cycle while the output is not stalled,
//   held whitespace read one entry per cycle from the hold buffer port.
// Reset: synchronous, active high; clears line state, sequencer and output valid.
//   The hold buffer is not cleared; only entries written on the line are read.
// ----------------------------------------------------------------------------
// pipe_and_quote_command_tokenizer_core
// Splits a byte stream into piped commands and quoted/whitespace arguments,
// streaming argument bytes, argument ends, command ends and a line status.
// ----------------------------------------------------------------------------
module pipe_and_quote_command_tokenizer_core import ptok_pkg::*; #(
   parameter int MAX_COMMANDS = MAX_COMMANDS_DEF,
   parameter int MAX_ARGS     = MAX_ARGS_DEF,
   parameter int HOLD_DEPTH   = HOLD_DEPTH_DEF
) (
   input  logic     clock,
   input  logic     reset,
   ptok_req_if.sink   req_chan,
   ptok_rsp_if.source rsp_chan
);

   localparam int ARG_W = $clog2(MAX_ARGS);
   localparam int PC_W  = $clog2(MAX_COMMANDS + 1);
   localparam int HC_W  = $clog2(HOLD_DEPTH + 1);
   localparam int HA_W  = $clog2(HOLD_DEPTH);

   typedef enum logic {ST_IDLE, ST_EMIT} state_type;

   state_type state_ff, state_in;

   // line state
   logic                 quote_open_ff,   quote_open_in;
   logic                 quote_single_ff, quote_single_in;
   logic                 token_open_ff,   token_open_in;
   logic [ARG_W-1:0]     arg_count_ff,    arg_count_in;
   logic [CMD_CNT_W-1:0] cmd_count_ff,    cmd_count_in;
   logic [PC_W-1:0]      pipe_count_ff,   pipe_count_in;
   logic [1:0]           seg_flags_ff,    seg_flags_in;
   logic [HC_W-1:0]      held_count_ff,   held_count_in;
   logic [1:0]           error_code_ff,   error_code_in;

   // pending results of the current byte
   logic [HC_W-1:0]      flush_cnt_ff,    flush_cnt_in;
   logic [HC_W-1:0]      flush_idx_ff,    flush_idx_in;
   logic                 pend_a_ff,       pend_a_in;
   logic                 a_is_end_ff,     a_is_end_in;
   logic [CHAR_W-1:0]    a_byte_ff,       a_byte_in;
   logic                 pend_c_ff,       pend_c_in;
   logic                 pend_ce_ff,      pend_ce_in;
   logic                 pend_s_ff,       pend_s_in;
   logic [STATUS_W-1:0]  status_ff,       status_in;
   logic [NUM_W-1:0]     run_cmd_ff,      run_cmd_in;
   logic [NUM_W-1:0]     run_arg_ff,      run_arg_in;

   // output register
   logic                 rsp_valid_ff,    rsp_valid_in;
   logic [KIND_W-1:0]    out_kind_ff,     out_kind_in;
   logic [CHAR_W-1:0]    out_byte_ff,     out_byte_in;
   logic [NUM_W-1:0]     out_cmd_ff,      out_cmd_in;
   logic [NUM_W-1:0]     out_arg_ff,      out_arg_in;
   logic [STATUS_W-1:0]  out_status_ff,   out_status_in;
   logic                 out_last_ff,     out_last_in;

   logic                 req_ready;
   logic                 req_fire;
   logic                 load_ok;
   logic                 hold_wr_en;
   logic [CHAR_W-1:0]    hold_rd_data;
   logic [ARG_W+2:0]     arg_ext;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_chan.valid & req_ready;
   assign load_ok   = ~rsp_valid_ff | rsp_chan.ready;
   assign arg_ext   = {3'b000, arg_count_ff};

   ptok_hold_mem #(
      .DEPTH (HOLD_DEPTH)
   ) u_hold (
      .clock   (clock),
      .wr_en   (hold_wr_en),
      .wr_addr (held_count_ff[HA_W-1:0]),
      .wr_data (req_chan.char_value),
      .rd_addr (flush_idx_in[HA_W-1:0]),
      .rd_data (hold_rd_data)
   );

   always_comb begin : step_logic
      logic              ws;
      logic [CHAR_W-1:0] c;
      logic [CHAR_W-1:0] qch;
      logic              more;

      state_in        = state_ff;
      quote_open_in   = quote_open_ff;
      quote_single_in = quote_single_ff;
      token_open_in   = token_open_ff;
      arg_count_in    = arg_count_ff;
      cmd_count_in    = cmd_count_ff;
      pipe_count_in   = pipe_count_ff;
      seg_flags_in    = seg_flags_ff;
      held_count_in   = held_count_ff;
      error_code_in   = error_code_ff;
      flush_cnt_in    = flush_cnt_ff;
      flush_idx_in    = flush_idx_ff;
      pend_a_in       = pend_a_ff;
      a_is_end_in     = a_is_end_ff;
      a_byte_in       = a_byte_ff;
      pend_c_in       = pend_c_ff;
      pend_ce_in      = pend_ce_ff;
      pend_s_in       = pend_s_ff;
      status_in       = status_ff;
      run_cmd_in      = run_cmd_ff;
      run_arg_in      = run_arg_ff;
      rsp_valid_in    = rsp_valid_ff & ~rsp_chan.ready;
      out_kind_in     = out_kind_ff;
      out_byte_in     = out_byte_ff;
      out_cmd_in      = out_cmd_ff;
      out_arg_in      = out_arg_ff;
      out_status_in   = out_status_ff;
      out_last_in     = out_last_ff;
      hold_wr_en      = 1'b0;
      c               = req_chan.char_value;
      ws              = is_ws(c);
      qch             = quote_single_ff ? SQUOTE : DQUOTE;
      more            = 1'b0;

      if (req_fire) begin
         flush_cnt_in = '0;
         flush_idx_in = '0;
         pend_a_in    = 1'b0;
         a_is_end_in  = 1'b0;
         a_byte_in    = c;
         pend_c_in    = 1'b0;
         pend_ce_in   = 1'b0;
         pend_s_in    = req_chan.end_of_line;
         run_cmd_in   = cmd_count_ff[NUM_W-1:0];
         run_arg_in   = arg_ext[NUM_W-1:0];

         if (c == PIPE_BYTE) begin
            if (token_open_ff) begin
               pend_a_in   = 1'b1;
               a_is_end_in = 1'b1;
            end
            token_open_in   = 1'b0;
            quote_open_in   = 1'b0;
            quote_single_in = 1'b0;
            held_count_in   = '0;
            if (seg_flags_ff[0]) begin
               pend_ce_in = 1'b1;
               if (cmd_count_ff != CMD_COUNT_MAX) cmd_count_in = cmd_count_ff + 1'b1;
            end else if (seg_flags_ff[1] && (pipe_count_ff != '0)) begin
               error_code_in = ERR_WS_SEG;
            end
            arg_count_in = '0;
            seg_flags_in = '0;
            if (pipe_count_ff < PC_W'(MAX_COMMANDS)) pipe_count_in = pipe_count_ff + 1'b1;
         end else begin
            seg_flags_in = {1'b1, seg_flags_ff[0] | ~ws};
            if (token_open_ff && quote_open_ff) begin
               if (c == qch) begin
                  // closing quote: held whitespace goes out, then the end
                  flush_cnt_in    = held_count_ff;
                  pend_a_in       = 1'b1;
                  a_is_end_in     = 1'b1;
                  arg_count_in    = arg_count_ff + 1'b1;
                  token_open_in   = 1'b0;
                  quote_open_in   = 1'b0;
                  quote_single_in = 1'b0;
                  held_count_in   = '0;
               end else if (ws) begin
                  if (held_count_ff < HC_W'(HOLD_DEPTH)) begin
                     hold_wr_en    = 1'b1;
                     held_count_in = held_count_ff + 1'b1;
                  end else if (error_code_ff == ERR_NONE) begin
                     error_code_in = ERR_OVERFLOW;
                  end
               end else begin
                  flush_cnt_in  = held_count_ff;
                  pend_a_in     = 1'b1;
                  held_count_in = '0;
               end
            end else if (token_open_ff) begin
               pend_a_in = 1'b1;
               if (ws) begin
                  a_is_end_in     = 1'b1;
                  arg_count_in    = arg_count_ff + 1'b1;
                  token_open_in   = 1'b0;
                  quote_open_in   = 1'b0;
                  quote_single_in = 1'b0;
                  held_count_in   = '0;
               end
            end else if (!ws && (arg_count_ff < ARG_W'(MAX_ARGS - 1))) begin
               token_open_in = 1'b1;
               if ((c == DQUOTE) || (c == SQUOTE)) begin
                  quote_open_in   = 1'b1;
                  quote_single_in = (c == SQUOTE);
                  held_count_in   = '0;
               end else begin
                  pend_a_in = 1'b1;
               end
            end
         end

         if (req_chan.end_of_line) begin
            // close the last segment, judge the line, then start clean
            pend_c_in = token_open_in;
            if (seg_flags_in[0]) begin
               pend_ce_in = 1'b1;
               if (cmd_count_in != CMD_COUNT_MAX) cmd_count_in = cmd_count_in + 1'b1;
            end
            priority if ((pipe_count_in == '0) && (cmd_count_in == '0)) begin
               status_in = STATUS_NO_CMDS;
            end else if (pipe_count_in >= PC_W'(MAX_COMMANDS)) begin
               status_in = STATUS_TOO_MANY;
            end else if (error_code_in == ERR_WS_SEG) begin
               status_in = STATUS_NO_CMDS;
            end else if (cmd_count_in == '0) begin
               status_in = STATUS_NO_CMDS;
            end else if (error_code_in == ERR_OVERFLOW) begin
               status_in = STATUS_OVERFLOW;
            end else begin
               status_in = STATUS_OK;
            end
            quote_open_in   = 1'b0;
            quote_single_in = 1'b0;
            token_open_in   = 1'b0;
            arg_count_in    = '0;
            cmd_count_in    = '0;
            pipe_count_in   = '0;
            seg_flags_in    = '0;
            held_count_in   = '0;
            error_code_in   = ERR_NONE;
         end

         if ((flush_cnt_in != '0) || pend_a_in || pend_c_in || pend_ce_in || pend_s_in) begin
            state_in = ST_EMIT;
         end
      end else if ((state_ff == ST_EMIT) && load_ok) begin
         rsp_valid_in  = 1'b1;
         out_byte_in   = '0;
         out_cmd_in    = run_cmd_ff;
         out_arg_in    = run_arg_ff;
         out_status_in = STATUS_OK;
         priority if (flush_idx_ff != flush_cnt_ff) begin
            out_kind_in  = KIND_ARG_BYTE;
            out_byte_in  = hold_rd_data;
            flush_idx_in = flush_idx_ff + 1'b1;
            more = (flush_idx_in != flush_cnt_ff) | pend_a_ff | pend_c_ff | pend_ce_ff
                   | pend_s_ff;
         end else if (pend_a_ff) begin
            out_kind_in = a_is_end_ff ? KIND_ARG_END : KIND_ARG_BYTE;
            out_byte_in = a_is_end_ff ? '0 : a_byte_ff;
            pend_a_in   = 1'b0;
            more        = pend_c_ff | pend_ce_ff | pend_s_ff;
         end else if (pend_c_ff) begin
            out_kind_in = KIND_ARG_END;
            pend_c_in   = 1'b0;
            more        = pend_ce_ff | pend_s_ff;
         end else if (pend_ce_ff) begin
            out_kind_in = KIND_CMD_END;
            out_arg_in  = '0;
            pend_ce_in  = 1'b0;
            more        = pend_s_ff;
         end else begin
            out_kind_in   = KIND_STATUS;
            out_cmd_in    = '0;
            out_arg_in    = '0;
            out_status_in = status_ff;
            pend_s_in     = 1'b0;
            more          = 1'b0;
         end
         out_last_in = ~more;
         if (!more) state_in = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         quote_open_ff   <= 1'b0;
         quote_single_ff <= 1'b0;
         token_open_ff   <= 1'b0;
         arg_count_ff    <= '0;
         cmd_count_ff    <= '0;
         pipe_count_ff   <= '0;
         seg_flags_ff    <= '0;
         held_count_ff   <= '0;
         error_code_ff   <= ERR_NONE;
         flush_cnt_ff    <= '0;
         flush_idx_ff    <= '0;
         pend_a_ff       <= 1'b0;
         pend_c_ff       <= 1'b0;
         pend_ce_ff      <= 1'b0;
         pend_s_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         quote_open_ff   <= quote_open_in;
         quote_single_ff <= quote_single_in;
         token_open_ff   <= token_open_in;
         arg_count_ff    <= arg_count_in;
         cmd_count_ff    <= cmd_count_in;
         pipe_count_ff   <= pipe_count_in;
         seg_flags_ff    <= seg_flags_in;
         held_count_ff   <= held_count_in;
         error_code_ff   <= error_code_in;
         flush_cnt_ff    <= flush_cnt_in;
         flush_idx_ff    <= flush_idx_in;
         pend_a_ff       <= pend_a_in;
         pend_c_ff       <= pend_c_in;
         pend_ce_ff      <= pend_ce_in;
         pend_s_ff       <= pend_s_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      a_is_end_ff   <= a_is_end_in;
      a_byte_ff     <= a_byte_in;
      status_ff     <= status_in;
      run_cmd_ff    <= run_cmd_in;
      run_arg_ff    <= run_arg_in;
      out_kind_ff   <= out_kind_in;
      out_byte_ff   <= out_byte_in;
      out_cmd_ff    <= out_cmd_in;
      out_arg_ff    <= out_arg_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   assign req_chan.ready           = req_ready;
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.kind            = out_kind_ff;
   assign rsp_chan.arg_byte        = out_byte_ff;
   assign rsp_chan.command_number  = out_cmd_ff;
   assign rsp_chan.argument_number = out_arg_ff;
   assign rsp_chan.line_status     = out_status_ff;
   assign rsp_chan.last_of_run     = out_last_ff;

endmodule
